FILE: design/hrdh_pkg.sv
// Shared types and constants for the mixed-radix route query block.
`default_nettype none

package hrdh_pkg;

	localparam int SIZE_REGS     = 4;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 9;
	localparam int DIMS_BITS     = 3;
	localparam int SIZE_BITS     = 9;
	localparam int KIND_BITS     = 8;
	localparam int FIELD_BITS    = 16;
	localparam int IN_DATA_BITS  = 32;
	localparam int OUT_DATA_BITS = 16;
	localparam int DIM_BITS      = 2;
	localparam int HOP_BITS      = 8;

	localparam logic [CFG_IDX_BITS-1:0] REG_DIMS  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_SIZE0 = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_SIZE1 = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_SIZE2 = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_SIZE3 = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_KIND  = 3'd5;

	typedef enum logic [1:0] {
		KIND_RING   = 2'd0,
		KIND_FULL   = 2'd1,
		KIND_SWITCH = 2'd2,
		KIND_RESV   = 2'd3
	} kind_t;

	typedef struct packed {
		logic                valid;
		logic                found;
		logic [DIM_BITS-1:0] dim;
	} ctl_t;

	typedef struct packed {
		logic                kind_reserved;
		logic                id_out_of_range;
		logic [HOP_BITS-1:0] hop_total;
		logic [DIM_BITS-1:0] route_dimension;
		logic                same_node;
	} result_t;

endpackage

`default_nettype wire

FILE: design/hrdh_cell.sv
// One restoring-division step on both ids, with digit compare at a dimension's last step.
`default_nettype none

module hrdh_cell #(
	parameter int ID_BITS    = 16,
	parameter int DIGIT_BITS = 8,
	parameter int DIM        = 0,
	parameter bit FIRST      = 1'b0,
	parameter bit LAST       = 1'b0
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     adv,
	input  wire  [DIGIT_BITS:0]     radix,
	input  hrdh_pkg::ctl_t          ctl_in,
	input  wire  [ID_BITS-1:0]      qs_in,
	input  wire  [ID_BITS-1:0]      qd_in,
	input  wire  [DIGIT_BITS-1:0]   rs_in,
	input  wire  [DIGIT_BITS-1:0]   rd_in,
	input  wire  [DIGIT_BITS-1:0]   sd_in,
	input  wire  [DIGIT_BITS-1:0]   dd_in,
	output hrdh_pkg::ctl_t          ctl_out,
	output logic [ID_BITS-1:0]      qs_out,
	output logic [ID_BITS-1:0]      qd_out,
	output logic [DIGIT_BITS-1:0]   rs_out,
	output logic [DIGIT_BITS-1:0]   rd_out,
	output logic [DIGIT_BITS-1:0]   sd_out,
	output logic [DIGIT_BITS-1:0]   dd_out
);

	localparam int DW = hrdh_pkg::DIM_BITS;

	logic [DIGIT_BITS-1:0] rs_w, rd_w, rs_n, rd_n, sd_n, dd_n;
	logic [DIGIT_BITS:0]   shs, shd;
	logic                  ges, ged;
	logic [ID_BITS-1:0]    qs_n, qd_n;
	hrdh_pkg::ctl_t        ctl_n, ctl_q;
	logic [ID_BITS-1:0]    qs_q, qd_q;
	logic [DIGIT_BITS-1:0] rs_q, rd_q, sd_q, dd_q;

	always_comb begin
		rs_w = FIRST ? '0 : rs_in;
		rd_w = FIRST ? '0 : rd_in;
		shs  = {rs_w, qs_in[ID_BITS-1]};
		shd  = {rd_w, qd_in[ID_BITS-1]};
		ges  = (shs >= radix);
		ged  = (shd >= radix);
		rs_n = ges ? DIGIT_BITS'(shs - radix) : shs[DIGIT_BITS-1:0];
		rd_n = ged ? DIGIT_BITS'(shd - radix) : shd[DIGIT_BITS-1:0];
		qs_n = {qs_in[ID_BITS-2:0], ges};
		qd_n = {qd_in[ID_BITS-2:0], ged};
		ctl_n = ctl_in;
		sd_n  = sd_in;
		dd_n  = dd_in;
		// record the highest differing digit pair seen so far
		if (LAST && (rs_n != rd_n)) begin
			ctl_n.found = 1'b1;
			ctl_n.dim   = DW'(DIM);
			sd_n        = rs_n;
			dd_n        = rd_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (adv) begin
			ctl_q <= ctl_n;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			qs_q <= qs_n;
			qd_q <= qd_n;
			rs_q <= rs_n;
			rd_q <= rd_n;
			sd_q <= sd_n;
			dd_q <= dd_n;
		end
	end

	assign ctl_out = ctl_q;
	assign qs_out  = qs_q;
	assign qd_out  = qd_q;
	assign rs_out  = rs_q;
	assign rd_out  = rd_q;
	assign sd_out  = sd_q;
	assign dd_out  = dd_q;

endmodule

`default_nettype wire

FILE: design/hrdh_out.sv
// Hop count from the chosen digit pair and a two-entry result buffer.
`default_nettype none

module hrdh_out #(
	parameter int DIGIT_BITS = 8
) (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  hrdh_pkg::ctl_t                          ctl_in,
	input  wire                                     oor,
	input  wire  [DIGIT_BITS-1:0]                   sd_in,
	input  wire  [DIGIT_BITS-1:0]                   dd_in,
	input  wire  [DIGIT_BITS:0]                     radix,
	input  wire  [hrdh_pkg::KIND_BITS-1:0]          kind_cfg,
	output logic                                    adv,
	output logic                                    m_axis_tvalid,
	input  wire                                     m_axis_tready,
	// same_node, route_dimension[2], hop_total[8], id_out_of_range, kind_reserved, zero pad
	output logic [hrdh_pkg::OUT_DATA_BITS-1:0]      m_axis_tdata
);

	localparam int HW = (DIGIT_BITS > hrdh_pkg::HOP_BITS) ? DIGIT_BITS : hrdh_pkg::HOP_BITS;

	logic [DIGIT_BITS-1:0] a, ring;
	logic [DIGIT_BITS:0]   b;
	logic [HW-1:0]         ring_w;
	hrdh_pkg::kind_t       kind;
	hrdh_pkg::result_t     res, out_res;
	hrdh_pkg::result_t     ent_q [2];
	logic [1:0]            cnt_q;
	logic                  wp_q, rp_q;
	logic                  push, pop;

	always_comb begin
		a      = (sd_in > dd_in) ? (sd_in - dd_in) : (dd_in - sd_in);
		b      = radix - {1'b0, a};
		ring   = ({1'b0, a} < b) ? a : b[DIGIT_BITS-1:0];
		ring_w = HW'(ring);
		kind   = hrdh_pkg::kind_t'(kind_cfg[{ctl_in.dim, 1'b0} +: 2]);
		res    = '0;
		if (oor) begin
			res.id_out_of_range = 1'b1;
		end else if (!ctl_in.found) begin
			res.same_node = 1'b1;
		end else begin
			res.route_dimension = ctl_in.dim;
			case (kind)
				hrdh_pkg::KIND_RING:   res.hop_total = ring_w[hrdh_pkg::HOP_BITS-1:0];
				hrdh_pkg::KIND_FULL:   res.hop_total = hrdh_pkg::HOP_BITS'(1);
				hrdh_pkg::KIND_SWITCH: res.hop_total = hrdh_pkg::HOP_BITS'(2);
				default:               res.kind_reserved = 1'b1;
			endcase
		end
	end

	assign adv           = (cnt_q != 2'd2);
	assign push          = adv && ctl_in.valid;
	assign m_axis_tvalid = (cnt_q != 2'd0);
	assign pop           = m_axis_tvalid && m_axis_tready;
	assign out_res       = ent_q[rp_q];
	assign m_axis_tdata  = hrdh_pkg::OUT_DATA_BITS'(out_res);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q] <= res;
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result buffer count overflow");

	a_cnt_push: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 2'd1)
		else $error("push without pop did not grow buffer");

	a_oor_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && out_res.id_out_of_range |->
			!out_res.same_node && out_res.hop_total == '0 &&
			!out_res.kind_reserved && out_res.route_dimension == '0)
		else $error("out-of-range item carries route fields");

	a_resv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && out_res.kind_reserved |-> out_res.hop_total == '0)
		else $error("reserved kind with nonzero hops");
`endif

endmodule

`default_nettype wire

FILE: design/hierarchical_route_dimension_hops.sv
// Top level: configuration registers, chain of division cells, result stage.
// Throughput: one item per cycle; each cell does one quotient bit per id per cycle.
// The chain stalls only while the two-entry result buffer is full.
// Reset: dims_in_use 1, all sizes 1, kinds 0 (ring); pipeline and result buffer empty.
`default_nettype none

module hierarchical_route_dimension_hops #(
	parameter int MAX_DIMS   = 4,
	parameter int ID_BITS    = 16,
	parameter int DIGIT_BITS = 8
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    cfg_valid,
	output logic                                   cfg_ready,
	input  wire  [hrdh_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  wire  [hrdh_pkg::CFG_DATA_BITS-1:0]     cfg_data,
	input  wire                                    s_axis_tvalid,
	output logic                                   s_axis_tready,
	// source_node[16], target_node[16]
	input  wire  [hrdh_pkg::IN_DATA_BITS-1:0]      s_axis_tdata,
	output logic                                   m_axis_tvalid,
	input  wire                                    m_axis_tready,
	// same_node, route_dimension[2], hop_total[8], id_out_of_range, kind_reserved, zero pad
	output logic [hrdh_pkg::OUT_DATA_BITS-1:0]     m_axis_tdata
);

	localparam int NREG = hrdh_pkg::SIZE_REGS;
	localparam int NDIM = (MAX_DIMS < NREG) ? MAX_DIMS : NREG;
	localparam int NST  = NDIM * ID_BITS;
	localparam int RW   = DIGIT_BITS + 1;
	localparam int CW   = (RW > hrdh_pkg::SIZE_BITS) ? RW : hrdh_pkg::SIZE_BITS;
	localparam int FB   = hrdh_pkg::FIELD_BITS;

	logic [hrdh_pkg::DIMS_BITS-1:0] dims_q, dims_eff;
	logic [hrdh_pkg::SIZE_BITS-1:0] size_q [NREG];
	logic [hrdh_pkg::KIND_BITS-1:0] kind_q;
	logic [RW-1:0]                  rad [NREG];
	logic [ID_BITS-1:0]             src_w, dst_w;
	logic                           adv, oor;

	hrdh_pkg::ctl_t        ctl_c [NST+1];
	logic [ID_BITS-1:0]    qs_c  [NST+1];
	logic [ID_BITS-1:0]    qd_c  [NST+1];
	logic [DIGIT_BITS-1:0] rs_c  [NST+1];
	logic [DIGIT_BITS-1:0] rd_c  [NST+1];
	logic [DIGIT_BITS-1:0] sd_c  [NST+1];
	logic [DIGIT_BITS-1:0] dd_c  [NST+1];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q <= hrdh_pkg::DIMS_BITS'(1);
			for (int i = 0; i < NREG; i++) size_q[i] <= hrdh_pkg::SIZE_BITS'(1);
			kind_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				hrdh_pkg::REG_DIMS:  dims_q    <= cfg_data[hrdh_pkg::DIMS_BITS-1:0];
				hrdh_pkg::REG_SIZE0: size_q[0] <= cfg_data[hrdh_pkg::SIZE_BITS-1:0];
				hrdh_pkg::REG_SIZE1: size_q[1] <= cfg_data[hrdh_pkg::SIZE_BITS-1:0];
				hrdh_pkg::REG_SIZE2: size_q[2] <= cfg_data[hrdh_pkg::SIZE_BITS-1:0];
				hrdh_pkg::REG_SIZE3: size_q[3] <= cfg_data[hrdh_pkg::SIZE_BITS-1:0];
				hrdh_pkg::REG_KIND:  kind_q    <= cfg_data[hrdh_pkg::KIND_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		dims_eff = dims_q;
		if (dims_q == '0) dims_eff = hrdh_pkg::DIMS_BITS'(1);
		if (dims_q > hrdh_pkg::DIMS_BITS'(NDIM)) dims_eff = hrdh_pkg::DIMS_BITS'(NDIM);
	end

	// saturate each size; dimensions beyond the count in use divide by one
	for (genvar k = 0; k < NREG; k++) begin : g_rad
		logic [CW-1:0] ext, cap, sat;
		always_comb begin
			ext = CW'(size_q[k]);
			cap = CW'(1) << DIGIT_BITS;
			if (ext == '0) sat = CW'(1);
			else if (ext > cap) sat = cap;
			else sat = ext;
			rad[k] = (hrdh_pkg::DIMS_BITS'(k) < dims_eff) ? RW'(sat) : RW'(1);
		end
	end

	if (ID_BITS <= FB) begin : g_id_narrow
		assign src_w = s_axis_tdata[ID_BITS-1:0];
		assign dst_w = s_axis_tdata[FB +: ID_BITS];
	end else begin : g_id_wide
		assign src_w = ID_BITS'(s_axis_tdata[FB-1:0]);
		assign dst_w = ID_BITS'(s_axis_tdata[FB +: FB]);
	end

	assign s_axis_tready = adv;

	assign ctl_c[0] = {s_axis_tvalid, 1'b0, {hrdh_pkg::DIM_BITS{1'b0}}};
	assign qs_c[0] = src_w;
	assign qd_c[0] = dst_w;
	assign rs_c[0] = '0;
	assign rd_c[0] = '0;
	assign sd_c[0] = '0;
	assign dd_c[0] = '0;

	for (genvar d = 0; d < NDIM; d++) begin : g_dim
		for (genvar s = 0; s < ID_BITS; s++) begin : g_step
			localparam int IX = d * ID_BITS + s;
			hrdh_cell #(
				.ID_BITS    (ID_BITS),
				.DIGIT_BITS (DIGIT_BITS),
				.DIM        (d),
				.FIRST      (s == 0),
				.LAST       (s == ID_BITS - 1)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.adv     (adv),
				.radix   (rad[d]),
				.ctl_in  (ctl_c[IX]),
				.qs_in   (qs_c[IX]),
				.qd_in   (qd_c[IX]),
				.rs_in   (rs_c[IX]),
				.rd_in   (rd_c[IX]),
				.sd_in   (sd_c[IX]),
				.dd_in   (dd_c[IX]),
				.ctl_out (ctl_c[IX+1]),
				.qs_out  (qs_c[IX+1]),
				.qd_out  (qd_c[IX+1]),
				.rs_out  (rs_c[IX+1]),
				.rd_out  (rd_c[IX+1]),
				.sd_out  (sd_c[IX+1]),
				.dd_out  (dd_c[IX+1])
			);
		end
	end

	// a quotient left over after all dimensions means the id reaches the node count
	assign oor = (|qs_c[NST]) || (|qd_c[NST]);

	hrdh_out #(
		.DIGIT_BITS (DIGIT_BITS)
	) u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl_in        (ctl_c[NST]),
		.oor           (oor),
		.sd_in         (sd_c[NST]),
		.dd_in         (dd_c[NST]),
		.radix         (rad[ctl_c[NST].dim]),
		.kind_cfg      (kind_q),
		.adv           (adv),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

`default_nettype wire

FILE: tb/hierarchical_route_dimension_hops_tb.sv
// Testbench for the mixed-radix route query block: directed and random queries, scoreboard check.
`default_nettype none

module hierarchical_route_dimension_hops_tb;
	import hrdh_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_PAD   = 80;

	class route_scoreboard;
		bit [DIMS_BITS-1:0] dims_reg;
		bit [SIZE_BITS-1:0] size_reg [SIZE_REGS];
		bit [KIND_BITS-1:0] kind_reg;
		result_t            pending_routes [$];
		int                 fails;

		function new();
			dims_reg = 1;
			foreach (size_reg[i]) size_reg[i] = 1;
			kind_reg = 0;
			fails = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
			case (idx)
				REG_DIMS:  dims_reg = val[DIMS_BITS-1:0];
				REG_SIZE0: size_reg[0] = val[SIZE_BITS-1:0];
				REG_SIZE1: size_reg[1] = val[SIZE_BITS-1:0];
				REG_SIZE2: size_reg[2] = val[SIZE_BITS-1:0];
				REG_SIZE3: size_reg[3] = val[SIZE_BITS-1:0];
				REG_KIND:  kind_reg = val[KIND_BITS-1:0];
				default: ;
			endcase
		endfunction

		function int unsigned dims_used();
			if (dims_reg < 1) return 1;
			if (dims_reg > SIZE_REGS) return SIZE_REGS;
			return dims_reg;
		endfunction

		function int unsigned radix(int unsigned d);
			if (size_reg[d] < 1) return 1;
			if (size_reg[d] > 256) return 256;
			return size_reg[d];
		endfunction

		function longint unsigned id_space();
			longint unsigned total;
			total = 1;
			for (int i = 0; i < dims_used(); i++) total *= radix(i);
			return total;
		endfunction

		function result_t predict_route(bit [FIELD_BITS-1:0] src, bit [FIELD_BITS-1:0] dst);
			result_t         res;
			longint unsigned total;
			int unsigned     rs, rd, n, dim, a, b;
			int unsigned     sdig [SIZE_REGS];
			int unsigned     ddig [SIZE_REGS];
			kind_t           k;
			res = '0;
			n = dims_used();
			total = id_space();
			if (src >= total || dst >= total) begin
				res.id_out_of_range = 1'b1;
				return res;
			end
			if (src == dst) begin
				res.same_node = 1'b1;
				return res;
			end
			rs = src;
			rd = dst;
			for (int i = 0; i < n; i++) begin
				sdig[i] = rs % radix(i);
				rs = rs / radix(i);
				ddig[i] = rd % radix(i);
				rd = rd / radix(i);
			end
			dim = 0;
			for (int i = n - 1; i >= 0; i--) begin
				if (sdig[i] != ddig[i]) begin
					dim = i;
					break;
				end
			end
			k = kind_t'(kind_reg[2*dim +: 2]);
			case (k)
				KIND_RING: begin
					a = (sdig[dim] > ddig[dim]) ? sdig[dim] - ddig[dim] : ddig[dim] - sdig[dim];
					b = radix(dim) - a;
					res.hop_total = HOP_BITS'((a < b) ? a : b);
				end
				KIND_FULL:   res.hop_total = HOP_BITS'(1);
				KIND_SWITCH: res.hop_total = HOP_BITS'(2);
				default:     res.kind_reserved = 1'b1;
			endcase
			res.route_dimension = dim[DIM_BITS-1:0];
			return res;
		endfunction

		function void note_query(bit [FIELD_BITS-1:0] src, bit [FIELD_BITS-1:0] dst);
			pending_routes.push_back(predict_route(src, dst));
		endfunction

		function void check_result(logic [OUT_DATA_BITS-1:0] tdata);
			result_t want, got;
			if (pending_routes.size() == 0) begin
				$error("result %h arrived with no query pending", tdata);
				fails++;
				return;
			end
			want = pending_routes.pop_front();
			got = tdata[$bits(result_t)-1:0];
			if (got.same_node !== want.same_node) begin
				$error("same_node: expected %0d, got %0d", want.same_node, got.same_node);
				fails++;
			end
			if (got.route_dimension !== want.route_dimension) begin
				$error("route_dimension: expected %0d, got %0d",
					want.route_dimension, got.route_dimension);
				fails++;
			end
			if (got.hop_total !== want.hop_total) begin
				$error("hop_total: expected %0d, got %0d", want.hop_total, got.hop_total);
				fails++;
			end
			if (got.id_out_of_range !== want.id_out_of_range) begin
				$error("id_out_of_range: expected %0d, got %0d",
					want.id_out_of_range, got.id_out_of_range);
				fails++;
			end
			if (got.kind_reserved !== want.kind_reserved) begin
				$error("kind_reserved: expected %0d, got %0d",
					want.kind_reserved, got.kind_reserved);
				fails++;
			end
			if (tdata[OUT_DATA_BITS-1:$bits(result_t)] !== '0) begin
				$error("pad: expected 0, got %0h", tdata[OUT_DATA_BITS-1:$bits(result_t)]);
				fails++;
			end
		endfunction
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [CFG_IDX_BITS-1:0]    cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]   cfg_data = '0;
	logic                       s_axis_tvalid = 1'b0;
	logic                       s_axis_tready;
	logic [IN_DATA_BITS-1:0]    s_axis_tdata = '0;
	logic                       m_axis_tvalid;
	logic                       m_axis_tready = 1'b0;
	logic [OUT_DATA_BITS-1:0]   m_axis_tdata;

	route_scoreboard sb = new();
	bit              calm = 1'b0;
	int unsigned     stall_left = 0;
	int unsigned     cycle_count = 0;

	hierarchical_route_dimension_hops u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("hierarchical_route_dimension_hops_tb: FAIL");
			$finish;
		end
	end

	// check results, then stall the result side in random bursts
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
		if (calm) begin
			m_axis_tready <= 1'b1;
		end else if (stall_left != 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 9) == 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= $urandom_range(0, 10);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
	endtask

	task automatic program_fabric(int unsigned dims, int unsigned s0, int unsigned s1,
			int unsigned s2, int unsigned s3, int unsigned kinds);
		write_reg(REG_DIMS, CFG_DATA_BITS'(dims));
		write_reg(REG_SIZE0, CFG_DATA_BITS'(s0));
		write_reg(REG_SIZE1, CFG_DATA_BITS'(s1));
		write_reg(REG_SIZE2, CFG_DATA_BITS'(s2));
		write_reg(REG_SIZE3, CFG_DATA_BITS'(s3));
		write_reg(REG_KIND, CFG_DATA_BITS'(kinds));
		cfg_valid <= 1'b0;
	endtask

	task automatic send_query(bit [FIELD_BITS-1:0] src, bit [FIELD_BITS-1:0] dst);
		if (!calm && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {dst, src};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_query(src, dst);
	endtask

	task automatic drain_queries();
		s_axis_tvalid <= 1'b0;
		while (sb.pending_routes.size() != 0) @(posedge clk);
		repeat (DRAIN_PAD) @(posedge clk);
	endtask

	function automatic int unsigned pick_size();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 8) return 0;
		if (r < 18) return 256;
		if (r < 26) return $urandom_range(257, 511);
		return $urandom_range(1, 24);
	endfunction

	task automatic random_query(output bit [FIELD_BITS-1:0] src, output bit [FIELD_BITS-1:0] dst);
		longint unsigned span, weight, old_digit, new_digit, value;
		int unsigned     r, d;
		span = sb.id_space();
		if (span > 65536) span = 65536;
		r = $urandom_range(0, 99);
		src = FIELD_BITS'($urandom_range(0, span - 1));
		if (r < 10) begin
			src = FIELD_BITS'($urandom());
			dst = FIELD_BITS'($urandom());
		end else if (r < 20) begin
			dst = src;
		end else if (r < 28) begin
			dst = FIELD_BITS'((span < 65536) ? $urandom_range(span, 65535) : $urandom());
			if ($urandom_range(0, 1)) {src, dst} = {dst, src};
		end else if (r < 55) begin
			dst = FIELD_BITS'($urandom_range(0, span - 1));
		end else begin
			// move one digit of the source, optionally scramble the digits below it
			d = $urandom_range(0, sb.dims_used() - 1);
			weight = 1;
			for (int i = 0; i < d; i++) weight *= sb.radix(i);
			old_digit = (src / weight) % sb.radix(d);
			new_digit = $urandom_range(0, sb.radix(d) - 1);
			value = src - old_digit * weight + new_digit * weight;
			if ($urandom_range(0, 1)) value = value - value % weight + $urandom() % weight;
			dst = FIELD_BITS'(value);
		end
	endtask

	initial begin
		bit [FIELD_BITS-1:0] src, dst;
		int unsigned         dims, r;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: one dimension of size one
		send_query(16'd0, 16'd0);
		send_query(16'd0, 16'd1);
		send_query(16'hFFFF, 16'd0);
		drain_queries();

		program_fabric(4, 4, 4, 4, 4, {KIND_RESV, KIND_SWITCH, KIND_FULL, KIND_RING});
		send_query(16'd0, 16'd1);
		send_query(16'd0, 16'd3);
		send_query(16'd0, 16'd2);
		send_query(16'd0, 16'd4);
		send_query(16'd5, 16'd21);
		send_query(16'd0, 16'd64);
		send_query(16'd255, 16'd0);
		send_query(16'd255, 16'd255);
		send_query(16'd256, 16'd0);
		send_query(16'd0, 16'd256);
		send_query(16'hFFFF, 16'hFFFF);
		drain_queries();

		program_fabric(2, 256, 256, 1, 1, {4{KIND_RING}});
		send_query(16'd0, 16'd128);
		send_query(16'd0, 16'd129);
		send_query(16'hFFFF, 16'd0);
		send_query(16'd0, 16'hFFFF);
		send_query(16'hFFFF, 16'hFFFE);
		send_query(16'h8000, 16'h0080);
		drain_queries();

		// saturated dimension count and sizes, all kinds reserved
		program_fabric(7, 511, 0, 300, 1, 8'hFF);
		send_query(16'd1, 16'd2);
		send_query(16'd256, 16'd0);
		send_query(16'hAAAA, 16'h5555);
		drain_queries();

		program_fabric(0, 10, 3, 3, 3, {4{KIND_SWITCH}});
		send_query(16'd9, 16'd3);
		send_query(16'd10, 16'd3);
		drain_queries();

		for (int phase = 0; phase < 12; phase++) begin
			r = $urandom_range(0, 99);
			if (r < 8) dims = 0;
			else if (r < 18) dims = $urandom_range(5, 7);
			else dims = $urandom_range(1, 4);
			if (phase == 0)
				program_fabric(2, 256, 256, pick_size(), pick_size(), $urandom_range(0, 255));
			else
				program_fabric(dims, pick_size(), pick_size(), pick_size(), pick_size(),
					$urandom_range(0, 255));
			calm = (phase == 11);
			for (int n = 0; n < 140; n++) begin
				random_query(src, dst);
				send_query(src, dst);
			end
			drain_queries();
		end

		if (sb.fails == 0)
			$display("hierarchical_route_dimension_hops_tb: PASS");
		else
			$display("hierarchical_route_dimension_hops_tb: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
